[design/kwm_pkg.sv]
// Shared types and codes for the k-way sorted merge block.
package kwm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } kwm_state_type;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_ROWS_IN_USE = 2'd0;
   localparam csr_index_type CSR_ROW_LENGTH  = 2'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [3:0] ROWS_IN_USE_RESET = 4'd8;
   localparam logic [4:0] ROW_LENGTH_RESET  = 5'd16;

endpackage

[design/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge: element memory, row cursors and head scan.
//
// Usage
//   req channel (valid/ready): req_func = 0 loads req_value at (req_row, req_col)
//   and clears every row cursor; req_func = 1 pops the smallest current head.
//   rsp channel (valid/ready): one result per pop, none per load. An exhausted
//   merge gives rsp_empty_res = 1 with value, row and column at zero.
//   csr port: rows_in_use at index 0, row_length at index 1, written whenever
//   csr_we is high. Write it only while the block is idle.
// Timing
//   A load is written on transfer and leaves the block idle. A pop walks the
//   rows in use (capped at MAX_ROWS) through the element memory, one row
//   issued per cycle; each head passes the registered memory read and then
//   the compare stage, and the block is idle again once the result is registered.
//   A new request is taken while a result still waits in the output register;
//   a pop that finishes before the receiver drains it holds until it can.
// Reset
//   Synchronous, active high: cursors cleared, rows_in_use = 8,
//   row_length = 16. The element memory is not cleared.
module k_way_sorted_merge #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_ROW_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [2:0]          req_row,
   input  logic [3:0]          req_col,
   input  logic signed [31:0]  req_value,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_out_value,
   output logic [2:0]          rsp_src_row,
   output logic [3:0]          rsp_src_col,
   output logic                rsp_empty_res,

   input  logic                csr_we,
   input  kwm_pkg::csr_index_type csr_index,
   input  logic [4:0]          csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_ROW_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int SW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_ROW_LEN + 1);

   // configuration
   logic [3:0] rows_ff;
   logic [4:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= kwm_pkg::ROWS_IN_USE_RESET;
         len_ff  <= kwm_pkg::ROW_LENGTH_RESET;
      end else if (csr_we) begin
         if (csr_index == kwm_pkg::CSR_ROWS_IN_USE) begin
            rows_ff <= csr_wdata[3:0];
         end else if (csr_index == kwm_pkg::CSR_ROW_LENGTH) begin
            len_ff <= csr_wdata;
         end
      end
   end

   logic [SW-1:0] nrows_sat;
   logic [CW-1:0] len_sat;

   assign nrows_sat = (32'(rows_ff) > MAX_ROWS)    ? SW'(MAX_ROWS)    : SW'(rows_ff);
   assign len_sat   = (32'(len_ff)  > MAX_ROW_LEN) ? CW'(MAX_ROW_LEN) : CW'(len_ff);

   // control
   kwm_pkg::kwm_state_type state_ff, state_in;

   logic req_xfer;
   logic is_load;
   logic is_pop;
   logic issue;
   logic scan_done;
   logic out_free;
   logic fin_fire;

   logic [SW-1:0] iss_ff, iss_in;

   logic          cmp_vld_ff;
   logic [RW-1:0] cmp_row_ff;
   logic [CW-1:0] cmp_col_ff;
   logic          cmp_live_ff;

   logic                best_found_ff;
   logic signed [31:0]  best_val_ff;
   logic [RW-1:0]       best_row_ff;
   logic [CW-1:0]       best_col_ff;

   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_value_ff;
   logic [2:0]          rsp_row_ff;
   logic [3:0]          rsp_col_ff;
   logic                rsp_empty_ff;

   logic [CW-1:0] cur_ff [MAX_ROWS];

   assign req_xfer  = req_valid && req_ready;
   assign is_load   = req_xfer && (req_func == kwm_pkg::FUNC_LOAD);
   assign is_pop    = req_xfer && (req_func == kwm_pkg::FUNC_POP);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_done = (iss_ff == nrows_sat) && !cmp_vld_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (is_pop) begin
               state_in = kwm_pkg::ST_SCAN;
            end
         end
         kwm_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = kwm_pkg::ST_FIN;
            end
         end
         kwm_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = kwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kwm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      fin_fire  = 1'b0;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         kwm_pkg::ST_SCAN: begin
            issue = (iss_ff < nrows_sat);
         end
         kwm_pkg::ST_FIN: begin
            fin_fire = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign iss_in = is_pop ? '0 : (issue ? iss_ff + SW'(1) : iss_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kwm_pkg::ST_IDLE;
         iss_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_ff     <= iss_in;
         cmp_vld_ff <= issue;
      end
   end

   // element memory; loads only in idle, read data used only while scanning, so no overlap
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [RW-1:0] iss_row;
   logic [CW-1:0] iss_cur;

   assign iss_row = iss_ff[RW-1:0];
   assign iss_cur = cur_ff[iss_row];
   assign mem_we  = is_load && (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_ROW_LEN);
   assign wr_addr = AW'(req_row) * AW'(MAX_ROW_LEN) + AW'(req_col);
   assign rd_addr = AW'(iss_row) * AW'(MAX_ROW_LEN) + AW'(iss_cur);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmp_row_ff  <= iss_row;
         cmp_col_ff  <= iss_cur;
         cmp_live_ff <= (iss_cur < len_sat);
      end
   end

   // running minimum; strict less keeps the lower row on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (is_pop) begin
         best_found_ff <= 1'b0;
      end else if (cmp_vld_ff && cmp_live_ff &&
                   (!best_found_ff || ($signed(rd_data_ff) < best_val_ff))) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_vld_ff && cmp_live_ff &&
          (!best_found_ff || ($signed(rd_data_ff) < best_val_ff))) begin
         best_val_ff <= $signed(rd_data_ff);
         best_row_ff <= cmp_row_ff;
         best_col_ff <= cmp_col_ff;
      end
   end

   // row cursors
   always_ff @(posedge clock) begin
      if (reset || is_load) begin
         for (int i = 0; i < MAX_ROWS; i++) begin
            cur_ff[i] <= '0;
         end
      end else if (fin_fire && best_found_ff) begin
         cur_ff[best_row_ff] <= best_col_ff + CW'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         rsp_value_ff <= best_found_ff ? best_val_ff : '0;
         rsp_row_ff   <= best_found_ff ? 3'(best_row_ff) : 3'd0;
         rsp_col_ff   <= best_found_ff ? 4'(best_col_ff) : 4'd0;
         rsp_empty_ff <= !best_found_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_src_row   = rsp_row_ff;
   assign rsp_src_col   = rsp_col_ff;
   assign rsp_empty_res = rsp_empty_ff;

   // checks
   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      iss_ff <= nrows_sat || state_ff != kwm_pkg::ST_SCAN)
      else $error("scan issued past the rows in use");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == kwm_pkg::ST_SCAN)
      else $error("compare stage busy outside the scan");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == kwm_pkg::ST_IDLE)
      else $error("element write during a pop");

   a_best_live: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && best_found_ff) |-> best_col_ff < len_sat)
      else $error("popped an exhausted row");

   a_fin_result: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> rsp_valid_ff && state_ff == kwm_pkg::ST_IDLE)
      else $error("finished pop without a result");

endmodule
